[rtl/psm_pkg.sv]
// Shared types, constants and the slot function of the packed symmetric matrix store.
`default_nettype none

package psm_pkg;

   localparam int INDEX_WIDTH   = 6;
   localparam int OPERAND_WIDTH = 32;
   localparam int DATA_WIDTH    = 32;
   localparam int SIZE_WIDTH    = 7;
   localparam int SLOT_WIDTH    = 11;

   localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_SUB   = 2'd2,
      OP_SWAP  = 2'd3
   } op_type;

   // Strobes from the controller to the datapath
   typedef struct packed {
      logic clear;     // write zero at the clearing pointer and advance it
      logic load;      // take a new word from the request channel
      logic rd_pair;   // read the entry of (a,b)
      logic wr_value;  // write the operand to the entry of (a,b)
      logic wr_diff;   // write read data minus operand to the entry of (a,b)
      logic cap_read;  // capture read data as the result
      logic sw_even;   // swap phase: read row a, write back row a of the previous k
      logic sw_odd;    // swap phase: read row b, write back row b of the previous k
      logic sw_read;   // issue the swap reads and advance k
      logic finish;    // load the response register
   } psm_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic   clr_done;
      logic   bad;
      logic   same;
      op_type op;
      logic   last_k;
      logic   out_free;
   } psm_stat_type;

   // Packed position of the pair (x,y): hi*(hi-1)/2 + lo
   function automatic logic [SLOT_WIDTH-1:0] slot_of(
      input logic [INDEX_WIDTH-1:0] x,
      input logic [INDEX_WIDTH-1:0] y
   );
      logic [INDEX_WIDTH-1:0] lo;
      logic [INDEX_WIDTH-1:0] hi;
      logic [SLOT_WIDTH:0]    prod;
      lo   = (x < y) ? x : y;
      hi   = (x < y) ? y : x;
      prod = (SLOT_WIDTH + 1)'(hi) * ((SLOT_WIDTH + 1)'(hi) - (SLOT_WIDTH + 1)'(1));
      return SLOT_WIDTH'(prod >> 1) + SLOT_WIDTH'(lo);
   endfunction

endpackage

`default_nettype wire

[rtl/psm_req_if.sv]
// Request channel interface: operation word with valid/ready handshake.
`default_nettype none

interface psm_req_if
   import psm_pkg::*;
();
   logic                            valid;
   logic                            ready;
   logic [1:0]                      opcode;
   logic [INDEX_WIDTH-1:0]          index_a;
   logic [INDEX_WIDTH-1:0]          index_b;
   logic signed [OPERAND_WIDTH-1:0] operand_value;

   modport source (output valid, opcode, index_a, index_b, operand_value, input ready);
   modport sink   (input valid, opcode, index_a, index_b, operand_value, output ready);
endinterface

`default_nettype wire

[rtl/psm_rsp_if.sv]
// Response channel interface: result word with valid/ready handshake.
`default_nettype none

interface psm_rsp_if
   import psm_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] read_data;
   logic                         status;

   modport source (output valid, read_data, status, input ready);
   modport sink   (input valid, read_data, status, output ready);
endinterface

`default_nettype wire

[rtl/packed_symmetric_matrix_store.sv]
// Flow: read and subtract go through decode, a read or subtract step and finish; write and a
// bad word or diagonal read go from decode to finish; swap walks the vertices in use, reading
// rows a and b in turn through the one RAM read port, then drains the last write-back.
// Throughput: one word at a time; the next request is taken once the response is registered,
// and a response still waiting for rsp ready holds the next word in finish until it leaves.
// Reset: synchronous, active high; matrix_size returns to 64 and a clearing pass writes zero
// to every store entry, one per cycle, and takes no request; size writes are taken throughout.
`default_nettype none

module packed_symmetric_matrix_store
   import psm_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int ENTRY_WIDTH  = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   psm_req_if.sink                    req_chan,
   psm_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_write_enable,
   input  wire logic [SIZE_WIDTH-1:0] csr_write_data
);

   psm_cmd_type  cmd;
   psm_stat_type stat;

   psm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   psm_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .ENTRY_WIDTH  (ENTRY_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_opcode        (req_chan.opcode),
      .req_index_a       (req_chan.index_a),
      .req_index_b       (req_chan.index_b),
      .req_operand_value (req_chan.operand_value),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_read_data     (rsp_chan.read_data),
      .rsp_status        (rsp_chan.status),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

`default_nettype wire

[rtl/psm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2016,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write when enabled; read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/psm_ctrl.sv]
// Controller state machine: sequences clear, read, write, subtract and swap.
`default_nettype none

module psm_ctrl
   import psm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire psm_stat_type stat,
   output psm_cmd_type       cmd
);

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b00_0000_0001,
      ST_IDLE   = 10'b00_0000_0010,
      ST_DECODE = 10'b00_0000_0100,
      ST_RD     = 10'b00_0000_1000,
      ST_SUB    = 10'b00_0001_0000,
      ST_SW_EV  = 10'b00_0010_0000,
      ST_SW_OD  = 10'b00_0100_0000,
      ST_DR_EV  = 10'b00_1000_0000,
      ST_DR_OD  = 10'b01_0000_0000,
      ST_FINISH = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Decode state into datapath strobes and pick the next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.bad) begin
               state_in = ST_FINISH;
            end else begin
               case (stat.op)
                  OP_READ: begin
                     if (stat.same) begin
                        state_in = ST_FINISH;
                     end else begin
                        cmd.rd_pair = 1'b1;
                        state_in    = ST_RD;
                     end
                  end
                  OP_WRITE: begin
                     cmd.wr_value = 1'b1;
                     state_in     = ST_FINISH;
                  end
                  OP_SUB: begin
                     cmd.rd_pair = 1'b1;
                     state_in    = ST_SUB;
                  end
                  OP_SWAP: begin
                     state_in = ST_SW_EV;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_RD: begin
            cmd.cap_read = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_SUB: begin
            cmd.wr_diff = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_SW_EV: begin
            cmd.sw_even = 1'b1;
            cmd.sw_read = 1'b1;
            state_in    = ST_SW_OD;
         end
         ST_SW_OD: begin
            cmd.sw_odd  = 1'b1;
            cmd.sw_read = 1'b1;
            state_in    = stat.last_k ? ST_DR_EV : ST_SW_EV;
         end
         // Drain the write-back of the last pair
         ST_DR_EV: begin
            cmd.sw_even = 1'b1;
            state_in    = ST_DR_OD;
         end
         ST_DR_OD: begin
            cmd.sw_odd = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = stat.out_free;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/psm_datapath.sv]
// Datapath: size register, item registers, address and data muxing, store RAM, response register.
`default_nettype none

module psm_datapath
   import psm_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int ENTRY_WIDTH  = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [SIZE_WIDTH-1:0]           csr_write_data,
   input  wire logic [1:0]                      req_opcode,
   input  wire logic [INDEX_WIDTH-1:0]          req_index_a,
   input  wire logic [INDEX_WIDTH-1:0]          req_index_b,
   input  wire logic signed [OPERAND_WIDTH-1:0] req_operand_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic signed [DATA_WIDTH-1:0]         rsp_read_data,
   output logic                                 rsp_status,
   input  wire psm_cmd_type                     cmd,
   output psm_stat_type                         stat
);

   localparam int DEPTH = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [SIZE_WIDTH-1:0]           size_ff;
   logic [SIZE_WIDTH-1:0]           size_eff;
   op_type                          op_ff;
   logic [INDEX_WIDTH-1:0]          a_ff;
   logic [INDEX_WIDTH-1:0]          b_ff;
   logic signed [OPERAND_WIDTH-1:0] v_ff;
   logic [INDEX_WIDTH-1:0]          k_ff;
   logic [INDEX_WIDTH-1:0]          kprev_ff;
   logic                            pend_ff;
   logic [ENTRY_WIDTH-1:0]          hold_ff;
   logic [DATA_WIDTH-1:0]           res_data_ff;
   logic [AW-1:0]                   clr_ff;
   logic                            rsp_valid_ff;
   logic [DATA_WIDTH-1:0]           rsp_data_ff;
   logic                            rsp_status_ff;

   logic                   same;
   logic                   bad;
   logic [ENTRY_WIDTH-1:0] v_ext;
   logic [ENTRY_WIDTH-1:0] rd_data;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [ENTRY_WIDTH-1:0] wr_data;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          pair_addr;

   // Clamp the size to the vertices that storage holds
   assign size_eff = (32'(size_ff) > MAX_VERTICES) ? SIZE_WIDTH'(MAX_VERTICES) : size_ff;

   assign same  = (a_ff == b_ff);
   assign bad   = ({1'b0, a_ff} >= size_eff) || ({1'b0, b_ff} >= size_eff)
                  || ((op_ff != OP_READ) && same);
   assign v_ext = ENTRY_WIDTH'(v_ff);
   assign pair_addr = AW'(slot_of(a_ff, b_ff));

   assign stat.clr_done = (clr_ff == AW'(DEPTH - 1));
   assign stat.bad      = bad;
   assign stat.same     = same;
   assign stat.op       = op_ff;
   // End the swap walk at the last vertex in use or at the last addressable index
   assign stat.last_k   = ({1'b0, k_ff} == (size_eff - SIZE_WIDTH'(1))) || (&k_ff);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // Select the write port source
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
      end else if (cmd.wr_value) begin
         wr_en   = 1'b1;
         wr_addr = pair_addr;
         wr_data = v_ext;
      end else if (cmd.wr_diff) begin
         wr_en   = 1'b1;
         wr_addr = pair_addr;
         wr_data = rd_data - v_ext;
      end else if (cmd.sw_even) begin
         wr_en   = pend_ff;
         wr_addr = AW'(slot_of(a_ff, kprev_ff));
         wr_data = rd_data;
      end else if (cmd.sw_odd) begin
         wr_en   = pend_ff;
         wr_addr = AW'(slot_of(b_ff, kprev_ff));
         wr_data = hold_ff;
      end
   end

   // Select the read address
   always_comb begin
      rd_addr = '0;
      if (cmd.rd_pair) begin
         rd_addr = pair_addr;
      end else if (cmd.sw_read && cmd.sw_even) begin
         rd_addr = AW'(slot_of(a_ff, k_ff));
      end else if (cmd.sw_read && cmd.sw_odd) begin
         rd_addr = AW'(slot_of(b_ff, k_ff));
      end
   end

   psm_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
         if (cmd.clear && !stat.clr_done) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.load) begin
            k_ff    <= '0;
            pend_ff <= 1'b0;
         end else if (cmd.sw_odd) begin
            pend_ff <= cmd.sw_read && (k_ff != a_ff) && (k_ff != b_ff);
            if (cmd.sw_read) begin
               k_ff <= k_ff + INDEX_WIDTH'(1);
            end
         end
         rsp_valid_ff <= cmd.finish || (rsp_valid_ff && !rsp_ready);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= op_type'(req_opcode);
         a_ff        <= req_index_a;
         b_ff        <= req_index_b;
         v_ff        <= req_operand_value;
         res_data_ff <= '0;
      end
      if (cmd.cap_read) begin
         res_data_ff <= DATA_WIDTH'(signed'(rd_data));
      end
      if (cmd.sw_odd && cmd.sw_read) begin
         hold_ff  <= rd_data;
         kprev_ff <= k_ff;
      end
      if (cmd.finish) begin
         rsp_data_ff   <= bad ? '0 : res_data_ff;
         rsp_status_ff <= bad;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

[rtl/psm_checker.sv]
// Port-level assertions for the packed symmetric matrix store, with its bind.
`default_nettype none

module psm_checker
   import psm_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [DATA_WIDTH-1:0] rsp_read_data,
   input wire logic                  rsp_status
);

   // Take no request in the cycle after reset: the clearing pass runs first
   a_no_accept_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request ready right after reset");

   // Drop ready once a word is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held after accepting a word");

   // Report zero data with an invalid status
   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_read_data == '0))
      else $error("invalid response carries data");

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_read_data) && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind packed_symmetric_matrix_store psm_checker u_psm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.read_data),
   .rsp_status    (rsp_chan.status)
);

`default_nettype wire
